/* sv/clcd_pkg.sv */
// ---------------------------------------------------------------------------
// clcd_pkg: shared types and constants for the column level crossing depth
// Sequencer states, the column summary struct and fixed datapath widths.
// ---------------------------------------------------------------------------
`default_nettype none

package clcd_pkg;

  // Fixed field widths
  localparam int SAMPLE_W = 32;
  localparam int START_W  = 24;
  localparam int DEPTH_W  = 28;
  localparam int LAYER_W  = 11;
  localparam int FRAC_W   = 16;

  // Divider operand widths: |num| << 16 over |den|
  localparam int DIVISOR_W  = 32;
  localparam int DIVIDEND_W = DIVISOR_W + FRAC_W;

  // Quotient magnitude clamp; anything at or above this saturates the depth
  localparam logic [29:0] QCLAMP = 30'h2000_0000;

  // Depth saturation limits (Q12.16 in a 32-bit sum)
  localparam logic signed [31:0] DEPTH_MAX = 32'sd134217727;
  localparam logic signed [31:0] DEPTH_MIN = -32'sd134217728;

  // Start position bias: one layer in Q16.8
  localparam logic signed [24:0] START_BIAS = 25'sd256;
  localparam logic signed [25:0] CEIL_ADD   = 26'sd255;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROUND,
    ST_DONE
  } state_t;

  // Column summary after the current sample
  typedef struct packed {
    logic                       found;
    logic signed [SAMPLE_W-1:0] upper;
    logic signed [SAMPLE_W-1:0] lower;
  } col_sum_t;

endpackage

`default_nettype wire

/* sv/clcd_scan.sv */
// ---------------------------------------------------------------------------
// clcd_scan: per-sample column scanner
// Tracks layer count and start layer, finds the first layer at or below the
// level and holds the samples around it. Presents the summary after the
// current sample combinationally.
// ---------------------------------------------------------------------------
`default_nettype none

module clcd_scan #(
  parameter int MAX_LAYERS = 1024,
  parameter int LW         = 11
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 accept,
  input  wire logic signed [clcd_pkg::SAMPLE_W-1:0] sample_value,
  input  wire logic signed [clcd_pkg::START_W-1:0]  start_position,
  input  wire logic                                 column_first,
  input  wire logic                                 column_last,
  input  wire logic signed [clcd_pkg::SAMPLE_W-1:0] level,
  output clcd_pkg::col_sum_t                        summary,
  output logic             [LW-1:0]                 summary_layer
);
  import clcd_pkg::*;

  localparam logic [LW-1:0] MAX_L  = LW'(MAX_LAYERS);
  localparam logic [17:0]   MAX_18 = 18'(MAX_LAYERS);

  logic             [LW-1:0]       layer_count;
  logic             [LW-1:0]       start_layer;
  logic signed      [SAMPLE_W-1:0] previous_sample;
  logic                            crossing_found;
  logic             [LW-1:0]       found_layer;
  logic signed      [SAMPLE_W-1:0] upper_sample;
  logic signed      [SAMPLE_W-1:0] lower_sample;

  logic signed [24:0] biased;
  logic signed [25:0] ceil_sum;
  logic        [17:0] start_ceil;
  logic    [LW-1:0]   start_new;
  logic    [LW-1:0]   k;
  logic    [LW-1:0]   st;
  logic               cf;
  logic               hit;
  logic    [LW-1:0]   count_inc;

  // Start layer: ceil(start - 1) clamped to [0, MAX_LAYERS]
  always_comb begin
    biased     = 25'(start_position) - START_BIAS;
    ceil_sum   = 26'(biased) + CEIL_ADD;
    start_ceil = (biased > 25'sd0) ? ceil_sum[25:8] : 18'd0;
    start_new  = (start_ceil > MAX_18) ? MAX_L : start_ceil[LW-1:0];
  end

  // Level test on the current layer
  always_comb begin
    k   = column_first ? '0 : layer_count;
    st  = column_first ? start_new : start_layer;
    cf  = column_first ? 1'b0 : crossing_found;
    hit = !cf && (k >= st) && (k < MAX_L) && (sample_value <= level);
    count_inc = (k == MAX_L) ? MAX_L : k + 1'b1;
  end

  // Summary including this sample
  always_comb begin
    summary.found = cf || hit;
    summary.upper = hit ? previous_sample : upper_sample;
    summary.lower = hit ? sample_value : lower_sample;
    summary_layer = hit ? k : found_layer;
  end

  // Column state; cleared after the column's last sample
  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count     <= '0;
      start_layer     <= '0;
      previous_sample <= '0;
      crossing_found  <= 1'b0;
      found_layer     <= '0;
      upper_sample    <= '0;
      lower_sample    <= '0;
    end else if (accept) begin
      previous_sample <= sample_value;
      found_layer     <= summary_layer;
      upper_sample    <= summary.upper;
      lower_sample    <= summary.lower;
      if (column_last) begin
        layer_count    <= '0;
        start_layer    <= '0;
        crossing_found <= 1'b0;
      end else begin
        layer_count    <= count_inc;
        start_layer    <= st;
        crossing_found <= summary.found;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/clcd_div.sv */
// ---------------------------------------------------------------------------
// clcd_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle. Done pulses when the
// last step is registered, quotient and remainder stable until next start.
// ---------------------------------------------------------------------------
`default_nettype none

module clcd_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [clcd_pkg::DIVIDEND_W-1:0]   dividend,
  input  wire logic [clcd_pkg::DIVISOR_W-1:0]    divisor,
  output logic                                   done,
  output logic [clcd_pkg::DIVIDEND_W-1:0]        quot,
  output logic [clcd_pkg::DIVISOR_W-1:0]         rem
);
  import clcd_pkg::*;

  localparam int CW = $clog2(DIVIDEND_W + 1);

  logic                 running;
  logic [CW-1:0]        count;
  logic [DIVISOR_W-1:0] dvsr;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 take;

  // One restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem, quot[DIVIDEND_W-1]};
    diff  = trial - {1'b0, dvsr};
    take  = (trial >= {1'b0, dvsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= running && (count == CW'(1));
      if (start) begin
        running <= 1'b1;
        count   <= CW'(DIVIDEND_W);
      end else if (running) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          running <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (running) begin
      quot <= {quot[DIVIDEND_W-2:0], take};
      rem  <= take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* sv/column_level_crossing_depth.sv */
// ---------------------------------------------------------------------------
// column_level_crossing_depth: level crossing depth of a sample column
// Scans one column of samples for the first layer at or below a level and
// interpolates the crossing depth with a shared iterative divider.
// ---------------------------------------------------------------------------
// Usage:
//   Samples enter on the in channel (in_valid / in_stall), one layer per
//   transfer, column_first on the top layer, column_last on the bottom one.
//   Samples that are not the last of a column are taken one per cycle while
//   the sequencer is idle. The last sample of a column yields one result on
//   the out channel (out_valid / out_stall). When a division is needed, the
//   divider runs its steps, the sequencer takes the done flag, rounds the
//   quotient and loads the output register, and the next sample is taken
//   once the sequencer is back in idle. Without a division the sequencer
//   goes straight to loading the output register and back to idle.
//   in_stall stays high while the result is formed; the one-bit-per-cycle
//   divider sets how long that lasts.
//   A finished result waits in the output register while out_stall is high;
//   samples of the next column are still taken, but that column's result
//   holds the sequencer, with in_stall high, until the register is free.
//   level_threshold is written through cfg_valid / cfg_ready, always ready;
//   the user writes it only while the block is idle; the block does not enforce it.
//   Synchronous reset clears the level to zero, the column state, the
//   sequencer and out_valid; no result is lost or repeated around a stall.
// ---------------------------------------------------------------------------
`default_nettype none

module column_level_crossing_depth #(
  parameter int MAX_LAYERS = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // Configuration
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic signed [clcd_pkg::SAMPLE_W-1:0]  level_threshold,
  // Sample channel
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [clcd_pkg::SAMPLE_W-1:0]  sample_value,
  input  wire logic signed [clcd_pkg::START_W-1:0]   start_position,
  input  wire logic                                  column_first,
  input  wire logic                                  column_last,
  // Result channel
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [clcd_pkg::DEPTH_W-1:0]        depth_value,
  output logic                                       depth_valid,
  output logic        [clcd_pkg::LAYER_W-1:0]        crossing_layer
);
  import clcd_pkg::*;

  localparam int LW = $clog2(MAX_LAYERS + 1);

  // Level register and sequencer
  logic signed [SAMPLE_W-1:0] level;
  state_t                     state;
  state_t                     state_next;

  // Scanner summary
  col_sum_t                   summary;
  logic [LW-1:0]              summary_layer;

  // Operand preparation
  logic signed [SAMPLE_W:0]   num;
  logic signed [SAMPLE_W:0]   den;
  logic [SAMPLE_W:0]          num_abs;
  logic [SAMPLE_W:0]          den_abs;
  logic                       has_layer;
  logic [LW+LAYER_W-1:0]      layer_wide;

  // Handshake and control
  logic                       in_accept;
  logic                       div_go;
  logic                       out_load;
  logic                       div_done;
  logic [DIVIDEND_W-1:0]      div_quot;
  logic [DIVISOR_W-1:0]       div_rem;

  // Per-column result registers
  logic                       res_valid;
  logic [LAYER_W-1:0]         res_layer;
  logic                       neg;
  logic [DIVISOR_W-1:0]       den_mag;
  logic [LW-1:0]              offset;
  logic [29:0]                qm;

  // Rounding and final sum
  logic                       round_up;
  logic [DIVIDEND_W:0]        q_rounded;
  logic [29:0]                qm_next;
  logic signed [31:0]         q_signed;
  logic signed [31:0]         depth_sum;
  logic signed [DEPTH_W-1:0]  depth_next;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;

  // Level register
  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (cfg_valid && cfg_ready) begin
      level <= level_threshold;
    end
  end

  // Column scanner
  clcd_scan #(
    .MAX_LAYERS (MAX_LAYERS),
    .LW         (LW)
  ) u_scan (
    .clk            (clk),
    .rst            (rst),
    .accept         (in_accept),
    .sample_value   (sample_value),
    .start_position (start_position),
    .column_first   (column_first),
    .column_last    (column_last),
    .level          (level),
    .summary        (summary),
    .summary_layer  (summary_layer)
  );

  // Interpolation operands from the summary
  always_comb begin
    num        = 33'(level) - 33'(summary.upper);
    den        = 33'(summary.lower) - 33'(summary.upper);
    num_abs    = num[SAMPLE_W] ? 33'(-num) : 33'(num);
    den_abs    = den[SAMPLE_W] ? 33'(-den) : 33'(den);
    has_layer  = summary.found && (summary_layer != '0);
    layer_wide = {{LAYER_W{1'b0}}, summary_layer};
    div_go     = in_accept && column_last && has_layer && (den != '0);
  end

  // Shared divider
  clcd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_go),
    .dividend ({num_abs[DIVISOR_W-1:0], {FRAC_W{1'b0}}}),
    .divisor  (den_abs[DIVISOR_W-1:0]),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Round to nearest, ties away, and clamp the magnitude
  always_comb begin
    round_up  = ({1'b0, div_rem, 1'b0} >= {2'b00, den_mag});
    q_rounded = {1'b0, div_quot} + (DIVIDEND_W+1)'(round_up);
    qm_next   = (q_rounded >= (DIVIDEND_W+1)'(QCLAMP)) ? QCLAMP : q_rounded[29:0];
  end

  // Depth = (layer - 1) + signed quotient, saturated; zero without a division
  always_comb begin
    q_signed  = neg ? -(32'(qm)) : 32'(qm);
    depth_sum = 32'({offset, {FRAC_W{1'b0}}}) + q_signed;
    if (!res_valid) begin
      depth_next = '0;
    end else if (depth_sum > DEPTH_MAX) begin
      depth_next = DEPTH_MAX[DEPTH_W-1:0];
    end else if (depth_sum < DEPTH_MIN) begin
      depth_next = DEPTH_MIN[DEPTH_W-1:0];
    end else begin
      depth_next = depth_sum[DEPTH_W-1:0];
    end
  end

  // Sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept && column_last) begin
          state_next = div_go ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: state_next = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_stall = 1'b1;
    out_load = 1'b0;
    unique case (state)
      ST_IDLE:  in_stall = 1'b0;
      ST_DIV:   in_stall = 1'b1;
      ST_ROUND: in_stall = 1'b1;
      ST_DONE:  out_load = !out_valid || !out_stall;
      default:  in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Per-column result capture
  always_ff @(posedge clk) begin
    if (in_accept && column_last) begin
      res_valid <= div_go;
      res_layer <= has_layer ? layer_wide[LAYER_W-1:0] : '0;
      neg       <= num[SAMPLE_W] != den[SAMPLE_W];
      den_mag   <= den_abs[DIVISOR_W-1:0];
      offset    <= summary_layer - 1'b1;
    end
    if (state == ST_ROUND) begin
      qm <= qm_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      depth_value    <= depth_next;
      depth_valid    <= res_valid;
      crossing_layer <= res_layer;
    end
  end

`ifndef SYNTHESIS
  // Divider finishes only while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider done outside division state");

  // A last sample with no division goes straight to result output
  a_invalid_to_done: assert property (@(posedge clk) disable iff (rst)
    (in_accept && column_last && !div_go) |=> state == ST_DONE)
    else $error("invalid column did not go to result output");

  // An invalid result carries a zero depth
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !depth_valid) |-> depth_value == '0)
    else $error("invalid result with nonzero depth");

  // A held result is not overwritten
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> !$past(out_load))
    else $error("result overwritten while stalled");
`endif

endmodule

`default_nettype wire

/* test/crossing_depth_checker.sv */
// ---------------------------------------------------------------------------
// crossing_depth_checker: scoreboard for the column level crossing depth
// Watches the level write port and both sample and result channels, keeps
// its own column scan state, predicts each column's depth result and
// compares every result transfer field by field in arrival order.
// ---------------------------------------------------------------------------
module crossing_depth_checker #(
  parameter int MAX_LAYERS = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic signed [clcd_pkg::SAMPLE_W-1:0] level_threshold,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic signed [clcd_pkg::SAMPLE_W-1:0] sample_value,
  input  logic signed [clcd_pkg::START_W-1:0]  start_position,
  input  logic                                 column_first,
  input  logic                                 column_last,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic signed [clcd_pkg::DEPTH_W-1:0]  depth_value,
  input  logic                                 depth_valid,
  input  logic        [clcd_pkg::LAYER_W-1:0]  crossing_layer,
  output int                                   mismatches,
  output int                                   pending,
  output int                                   results_seen
);
  import clcd_pkg::*;

  typedef struct packed {
    logic signed [DEPTH_W-1:0] depth;
    logic                      valid;
    logic [LAYER_W-1:0]        layer;
  } depth_result_t;

  // Predicted column state
  logic signed [SAMPLE_W-1:0] level_q;
  int unsigned                layer_cnt;
  int unsigned                start_lyr;
  int unsigned                found_lyr;
  logic                       found;
  logic signed [SAMPLE_W-1:0] prev_smp;
  logic signed [SAMPLE_W-1:0] upper_q;
  logic signed [SAMPLE_W-1:0] lower_q;

  depth_result_t expected_depths[$];
  depth_result_t oldest;
  int            err_count;
  int            result_count;

  // (num / den) in Q.16, rounded to nearest, ties away from zero
  function automatic longint rounded_ratio(longint num, longint den);
    longint unsigned a, b, q;
    logic            neg;
    neg = (num < 0) != (den < 0);
    a   = (num < 0) ? -num : num;
    a   = a << FRAC_W;
    b   = (den < 0) ? -den : den;
    q   = (2 * a + b) / (2 * b);
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // One accepted sample; queues a depth result on the bottom layer
  function void scan_sample(logic signed [SAMPLE_W-1:0] smp,
                            logic signed [START_W-1:0] pos,
                            logic top, logic bottom);
    longint        t, sl, d;
    depth_result_t r;
    if (top) begin
      // start layer = ceil(pos - 1), clamped to [0, MAX_LAYERS]
      t         = longint'(pos) - 256;
      sl        = (t > 0) ? ((t + 255) >>> 8) : 0;
      start_lyr = (sl > MAX_LAYERS) ? MAX_LAYERS : int'(sl);
      layer_cnt = 0;
      found     = 1'b0;
    end
    if (!found && layer_cnt >= start_lyr && layer_cnt < MAX_LAYERS &&
        smp <= level_q) begin
      found     = 1'b1;
      found_lyr = layer_cnt;
      lower_q   = smp;
      upper_q   = prev_smp;
    end
    prev_smp = smp;
    if (layer_cnt < MAX_LAYERS)
      layer_cnt++;
    if (bottom) begin
      r = '0;
      if (found && found_lyr >= 1) begin
        r.layer = found_lyr[LAYER_W-1:0];
        // equal samples give no depth, only the layer
        if (lower_q != upper_q) begin
          d = (longint'(found_lyr) - 1) * 65536 +
              rounded_ratio(longint'(level_q) - longint'(upper_q),
                            longint'(lower_q) - longint'(upper_q));
          if (d > 134217727)
            d = 134217727;
          if (d < -134217728)
            d = -134217728;
          r.depth = d[DEPTH_W-1:0];
          r.valid = 1'b1;
        end
      end
      expected_depths.push_back(r);
      layer_cnt = 0;
      start_lyr = 0;
      found     = 1'b0;
    end
  endfunction

  // Monitor: results first, then the new sample, then level write
  always @(posedge clk) begin
    if (rst) begin
      level_q   = '0;
      layer_cnt = 0;
      start_lyr = 0;
      found_lyr = 0;
      found     = 1'b0;
      prev_smp  = '0;
      upper_q   = '0;
      lower_q   = '0;
      expected_depths.delete();
    end else begin
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_depths.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: result transfer with none expected: depth %0d valid %0b layer %0d",
                     $time, depth_value, depth_valid, crossing_layer);
        end else begin
          oldest = expected_depths.pop_front();
          if (depth_value !== oldest.depth || depth_valid !== oldest.valid ||
              crossing_layer !== oldest.layer) begin
            err_count++;
            if (err_count <= 10)
              $display({"%0t: depth mismatch: expected depth %0d valid %0b layer %0d,",
                        " got depth %0d valid %0b layer %0d"},
                       $time, oldest.depth, oldest.valid, oldest.layer,
                       depth_value, depth_valid, crossing_layer);
          end
        end
      end
      if (in_valid && !in_stall)
        scan_sample(sample_value, start_position, column_first, column_last);
      if (cfg_valid && cfg_ready)
        level_q = level_threshold;
    end
    mismatches   <= err_count;
    pending      <= expected_depths.size();
    results_seen <= result_count;
  end

endmodule

/* test/column_level_crossing_depth_tb.sv */
// ---------------------------------------------------------------------------
// column_level_crossing_depth_tb: testbench for the crossing depth block
// Drives sample columns under several levels: a directed set of corner
// columns, then random columns with noise, random stalls and idle cycles.
// The checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
module column_level_crossing_depth_tb;
  import clcd_pkg::*;

  localparam int MAX_LAYERS    = 1024;
  localparam int SETTLE_CYCLES = 64;      // division plus rounding and output
  localparam int CYCLE_LIMIT   = 600000;
  localparam int PHASE_ITEMS   = 50;

  localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7FFF_FFFF;

  typedef enum int {
    SHAPE_DESCEND, SHAPE_SCATTER, SHAPE_ABOVE, SHAPE_PLATEAU
  } col_shape_t;

  logic                       clk             = 1'b0;
  logic                       rst             = 1'b1;
  logic                       cfg_valid       = 1'b0;
  logic signed [SAMPLE_W-1:0] level_threshold = '0;
  logic                       in_valid        = 1'b0;
  logic signed [SAMPLE_W-1:0] sample_value    = '0;
  logic signed [START_W-1:0]  start_position  = '0;
  logic                       column_first    = 1'b0;
  logic                       column_last     = 1'b0;
  logic                       out_stall       = 1'b0;
  logic                       cfg_ready;
  logic                       in_stall;
  logic                       out_valid;
  logic signed [DEPTH_W-1:0]  depth_value;
  logic                       depth_valid;
  logic        [LAYER_W-1:0]  crossing_layer;

  int mismatches;
  int pending;
  int results_seen;
  int cycle_count  = 0;
  int items_sent   = 0;
  int columns_sent = 0;
  int long_left    = 1;
  bit quiet        = 1'b0;
  logic signed [SAMPLE_W-1:0] cur_level = '0;

  column_level_crossing_depth #(.MAX_LAYERS(MAX_LAYERS)) uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .level_threshold(level_threshold),
    .in_valid(in_valid), .in_stall(in_stall), .sample_value(sample_value),
    .start_position(start_position), .column_first(column_first),
    .column_last(column_last),
    .out_valid(out_valid), .out_stall(out_stall), .depth_value(depth_value),
    .depth_valid(depth_valid), .crossing_layer(crossing_layer)
  );

  crossing_depth_checker #(.MAX_LAYERS(MAX_LAYERS)) u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .level_threshold(level_threshold),
    .in_valid(in_valid), .in_stall(in_stall), .sample_value(sample_value),
    .start_position(start_position), .column_first(column_first),
    .column_last(column_last),
    .out_valid(out_valid), .out_stall(out_stall), .depth_value(depth_value),
    .depth_valid(depth_valid), .crossing_layer(crossing_layer),
    .mismatches(mismatches), .pending(pending), .results_seen(results_seen)
  );

  // Clock: period 20
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side backpressure, off during the quiet stretch
  always @(posedge clk)
    out_stall <= !quiet && ($urandom_range(99) < 7);

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, pending);
      $display("column_level_crossing_depth_tb: FAIL");
      $finish;
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] clamp32(longint v);
    if (v > longint'(S_MAX))
      return S_MAX;
    if (v < longint'(S_MIN))
      return S_MIN;
    return v[SAMPLE_W-1:0];
  endfunction

  // Random sample, mostly near the current level
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    longint lvl;
    lvl = longint'(cur_level);
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return S_MIN;
      2:       return S_MAX;
      3, 4, 5: return clamp32(lvl + longint'($urandom_range(0, 16)) - 8);
      6, 7:    return clamp32(lvl + longint'($urandom_range(0, 1 << 20)) - (1 << 19));
      8:       return clamp32(lvl - longint'($urandom_range(0, 1 << 30)));
      default: return clamp32(lvl + longint'($urandom_range(0, 1 << 30)));
    endcase
  endfunction

  // One sample transfer, with random idle cycles ahead of it
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] smp,
                             input logic signed [START_W-1:0] pos,
                             input logic top, input logic bottom);
    while (!quiet && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    sample_value   <= smp;
    start_position <= pos;
    column_first   <= top;
    column_last    <= bottom;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    items_sent++;
    if (bottom)
      columns_sent++;
  endtask

  // Wait until every result is back and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_level(input logic signed [SAMPLE_W-1:0] lvl);
    settle();
    cfg_valid       <= 1'b1;
    level_threshold <= lvl;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
    cfg_valid <= 1'b0;
    cur_level = lvl;
  endtask

  // Random column: shape, length, start and marks all drawn at random
  task automatic send_random_column(input bit force_long);
    int                         len, cross_at, pick, i;
    col_shape_t                 shape;
    logic signed [START_W-1:0]  pos;
    logic signed [SAMPLE_W-1:0] plateau;
    longint                     lvl, v, step;
    bit                         has_top, has_bottom;
    lvl  = longint'(cur_level);
    pick = $urandom_range(99);
    if (force_long || (pick < 2 && long_left > 0)) begin
      // runs up to or past MAX_LAYERS
      len = $urandom_range(1020, 1032);
      long_left--;
    end else if (pick < 60) begin
      len = $urandom_range(1, 6);
    end else if (pick < 90) begin
      len = $urandom_range(7, 16);
    end else begin
      len = $urandom_range(17, 40);
    end
    pick = $urandom_range(99);
    if (pick < 70)
      pos = START_W'($urandom_range(0, len * 256 + 256));
    else if (pick < 80)
      pos = START_W'(-int'($urandom_range(0, 512)));
    else
      pos = START_W'($urandom);
    cross_at   = (len > 1000) ? $urandom_range(1018, len - 1) : $urandom_range(0, len - 1);
    step       = longint'($urandom_range(1, 1 << 20));
    plateau    = pick_sample();
    shape      = col_shape_t'($urandom_range(3));
    has_top    = $urandom_range(99) >= 8;
    has_bottom = $urandom_range(99) >= 5;
    for (i = 0; i < len; i++) begin
      case (shape)
        SHAPE_DESCEND:
          if (i < cross_at)
            v = lvl + longint'(cross_at - i) * step;
          else if (i == cross_at)
            v = lvl - longint'($urandom_range(0, 1 << 16));
          else
            v = longint'(pick_sample());
        SHAPE_SCATTER: v = longint'(pick_sample());
        SHAPE_ABOVE:   v = lvl + 1 + longint'($urandom_range(0, 1 << 24));
        default:
          v = ($urandom_range(3) == 0) ? longint'(pick_sample()) : longint'(plateau);
      endcase
      push_sample(clamp32(v), (i == 0) ? pos : START_W'($urandom),
                  has_top && i == 0, has_bottom && i == len - 1);
    end
  endtask

  initial begin
    int phase, phase_end;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset level zero, column with no top mark
    push_sample(32'sd100, 24'sd0, 1'b0, 1'b0);
    push_sample(32'sd50, 24'sd0, 1'b0, 1'b0);
    push_sample(-32'sd30, 24'sd0, 1'b0, 1'b1);
    // single-layer column crossing at layer zero
    push_sample(-32'sd5, 24'sd0, 1'b1, 1'b1);
    // top mark again in the middle of a column
    push_sample(32'sd50, 24'sd0, 1'b1, 1'b0);
    push_sample(32'sd40, 24'sd0, 1'b0, 1'b0);
    push_sample(-32'sd10, 24'sh000100, 1'b1, 1'b1);
    // ties away from zero, positive then negative (f0 not tested)
    push_sample(32'sd1, 24'sd0, 1'b1, 1'b0);
    push_sample(-32'sd131071, 24'sd0, 1'b0, 1'b1);
    push_sample(-32'sd1, 24'sh000200, 1'b1, 1'b0);
    push_sample(-32'sd131073, 24'sd0, 1'b0, 1'b1);
    // negative saturation
    push_sample(S_MIN + 1, 24'sh000200, 1'b1, 1'b0);
    push_sample(S_MIN, 24'sd0, 1'b0, 1'b1);

    // Highest level: positive saturation, fractional start, equal samples
    write_level(S_MAX);
    push_sample(S_MIN, 24'sh000200, 1'b1, 1'b0);
    push_sample(S_MIN + 1, 24'sd0, 1'b0, 1'b1);
    push_sample(S_MIN, 24'sh000280, 1'b1, 1'b0);
    push_sample(S_MIN + 1, 24'sd0, 1'b0, 1'b0);
    push_sample(32'sd5, 24'sd0, 1'b0, 1'b1);
    push_sample(32'sd7, 24'sh000200, 1'b1, 1'b0);
    push_sample(32'sd7, 24'sd0, 1'b0, 1'b1);
    // start beyond the column
    push_sample(32'sd0, 24'sh7FFFFF, 1'b1, 1'b0);
    push_sample(32'sd0, 24'sd0, 1'b0, 1'b1);

    // Lowest level: no crossing, most negative start
    write_level(S_MIN);
    push_sample(S_MAX, 24'sh800000, 1'b1, 1'b0);
    push_sample(S_MIN + 1, 24'sd0, 1'b0, 1'b1);

    // Level 1.0: interpolation that needs rounding
    write_level(32'sh0001_0000);
    push_sample(32'sh0003_0000, 24'sh000180, 1'b1, 1'b0);
    push_sample(32'sh0002_0000, 24'sd0, 1'b0, 1'b0);
    push_sample(32'sh0000_8000, 24'sd0, 1'b0, 1'b1);

    // Random phases, one level each; the zero-level phase runs without idling
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0:       write_level(S_MIN);
        1:       write_level(S_MAX);
        2:       write_level('0);
        3:       write_level($urandom);
        default: write_level(SAMPLE_W'(int'($urandom_range(0, 2000)) - 1000) <<< 8);
      endcase
      quiet     = (phase == 2);
      phase_end = items_sent + PHASE_ITEMS;
      if (phase == 0)
        send_random_column(1'b1);
      while (items_sent < phase_end) begin
        // occasional junk transfers with random marks
        if ($urandom_range(99) < 5)
          repeat ($urandom_range(1, 3))
            push_sample($urandom, START_W'($urandom),
                        1'($urandom_range(1)), 1'($urandom_range(1)));
        send_random_column(1'b0);
      end
    end
    quiet = 1'b0;
    settle();

    $display("column_level_crossing_depth_tb: %0d samples, %0d bottom marks, %0d results checked",
             items_sent, columns_sent, results_seen);
    $display({"column_level_crossing_depth_tb: levels at both extremes, zero and random;",
              " %0d mismatches"}, mismatches);
    if (mismatches == 0 && pending == 0)
      $display("column_level_crossing_depth_tb: PASS");
    else
      $display("column_level_crossing_depth_tb: FAIL");
    $finish;
  end

endmodule

/* filelist.f */
sv/clcd_pkg.sv
sv/clcd_scan.sv
sv/clcd_div.sv
sv/column_level_crossing_depth.sv
test/crossing_depth_checker.sv
test/column_level_crossing_depth_tb.sv
